// ===== hw/rtl/etcd_pkg.sv =====
// ----------------------------------------------------------------------------
// etcd_pkg
// Shared types, constants and helpers for the ETC1 block pixel decoder.
// ----------------------------------------------------------------------------
package etcd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic ADDR_ALPHA_MODE = 1'b0;

    localparam logic [7:0] MOD_SMALL [8] = '{8'd2, 8'd5, 8'd9, 8'd13,
                                              8'd18, 8'd24, 8'd33, 8'd47};
    localparam logic [7:0] MOD_LARGE [8] = '{8'd8, 8'd17, 8'd29, 8'd42,
                                              8'd60, 8'd80, 8'd106, 8'd183};

    typedef struct packed {
        logic [2:0][7:0] base0;
        logic [2:0][7:0] base1;
        logic            flip;
        logic [2:0]      tbl0;
        logic [2:0]      tbl1;
        logic [15:0]     sel_lo;
        logic [15:0]     sel_hi;
        logic [63:0]     alpha;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } desc_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic signed [8:0] mod_offset(input logic [2:0] tbl,
                                                     input logic [1:0] sel);
        logic [8:0] mag;
        mag = sel[0] ? {1'b0, MOD_LARGE[tbl]} : {1'b0, MOD_SMALL[tbl]};
        return sel[1] ? signed'(-mag) : signed'(mag);
    endfunction

endpackage

// ===== hw/rtl/etcd_intf.sv =====
// ----------------------------------------------------------------------------
// etcd_intf
// Valid/ready channels: compressed block in, decoded pixel out.
// ----------------------------------------------------------------------------
interface etcd_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] color_block;
    logic [63:0] alpha_block;

    modport source (output valid, output color_block, output alpha_block, input ready);
    modport sink   (input valid, input color_block, input alpha_block, output ready);
endinterface

interface etcd_pix_if;
    logic       valid;
    logic       ready;
    logic [1:0] pixel_x;
    logic [1:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
    logic       last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output red,
                    output green, output blue, output opacity, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input red,
                    input green, input blue, input opacity, input last_pixel,
                    output ready);
endinterface

// ===== hw/rtl/etc1_block_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// etc1_block_pixel_decoder
// ETC1 4x4 block decoder with optional explicit 4-bit alpha, one pixel a cycle while pix is ready.
//
//   channel | dir | payload                          | transfer per
//   blk     | in  | color_block, alpha_block         | block
//   pix     | out | pixel_x/y, rgb, opacity, last    | pixel (16 per block)
//   apb     | in  | alpha_mode at byte address 0     | register write
//
// The pixel counter in the back end walks the sixteen pixels of a block; a block
// is written into the queue, and its first pixel then into the output register.
// Reset clears the queue, counter, output valid and alpha_mode.
// A stalled pix channel holds its pixel; blocks keep entering until the
// queue is full.
// ----------------------------------------------------------------------------
module etc1_block_pixel_decoder
    import etcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    etcd_blk_if.sink          blk,
    etcd_pix_if.source        pix
);

    logic       alpha_mode_reg, alpha_mode_next;
    logic       cfg_wr;
    desc_push_t push;
    q_stat_t    q_stat;
    desc_t      head;
    logic       pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ADDR_ALPHA_MODE) ? {{(DATA_W-1){1'b0}}, alpha_mode_reg}
                                                  : '0;
    assign alpha_mode_next = (cfg_wr && paddr[2] == ADDR_ALPHA_MODE) ? pwdata[0]
                                                                      : alpha_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_mode_reg <= 1'b0;
        else
            alpha_mode_reg <= alpha_mode_next;
    end

    etcd_front u_front
    (
        .blk    (blk),
        .q_stat (q_stat),
        .push   (push)
    );

    etcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    etcd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .alpha_mode (alpha_mode_reg),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .pix        (pix)
    );

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.last_pixel |-> pix.pixel_x == 2'd3 && pix.pixel_y == 2'd3)
        else $error("last pixel not at bottom-right corner");

    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && !alpha_mode_reg |-> pix.opacity == 8'hff)
        else $error("opacity not 255 in opaque mode");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready && !pix.last_pixel |=> pix.valid)
        else $error("gap inside a block's pixel run");

endmodule

// ===== hw/rtl/etcd_front.sv =====
// ----------------------------------------------------------------------------
// etcd_front
// Accepts a block, decodes base colours and mode bits into a descriptor.
// ----------------------------------------------------------------------------
module etcd_front
    import etcd_pkg::*;
(
    etcd_blk_if.sink   blk,
    input  q_stat_t    q_stat,
    output desc_push_t push
);

    logic [63:0] cw;
    logic        diff;
    logic [4:0]  b5    [3];
    logic [2:0]  d3    [3];
    logic [5:0]  sum6  [3];
    logic [4:0]  c5    [3];
    logic [3:0]  ia    [3];
    logic [3:0]  ib    [3];

    assign cw        = blk.color_block;
    assign diff      = cw[33];
    assign blk.ready = !q_stat.full;

    always_comb
    begin
        push.valid       = blk.valid && !q_stat.full;
        push.desc.flip   = cw[32];
        push.desc.tbl0   = cw[39:37];
        push.desc.tbl1   = cw[36:34];
        push.desc.sel_lo = cw[15:0];
        push.desc.sel_hi = cw[31:16];
        push.desc.alpha  = blk.alpha_block;
        for (int ch = 0; ch < 3; ch++)
        begin
            b5[ch]   = cw[63 - 8 * ch -: 5];
            d3[ch]   = cw[58 - 8 * ch -: 3];
            ia[ch]   = cw[63 - 8 * ch -: 4];
            ib[ch]   = cw[59 - 8 * ch -: 4];
            sum6[ch] = {1'b0, b5[ch]} + {{3{d3[ch][2]}}, d3[ch]};
            // bit 5 set: below 0 for a negative delta, above 31 for a positive one
            if (sum6[ch][5])
                c5[ch] = d3[ch][2] ? 5'd0 : 5'd31;
            else
                c5[ch] = sum6[ch][4:0];
            if (diff)
            begin
                push.desc.base0[ch] = {b5[ch], b5[ch][4:2]};
                push.desc.base1[ch] = {c5[ch], c5[ch][4:2]};
            end
            else
            begin
                push.desc.base0[ch] = {ia[ch], ia[ch]};
                push.desc.base1[ch] = {ib[ch], ib[ch]};
            end
        end
    end

endmodule

// ===== hw/rtl/etcd_queue.sv =====
// ----------------------------------------------------------------------------
// etcd_queue
// Short descriptor queue between front and back.
// ----------------------------------------------------------------------------
module etcd_queue
    import etcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  desc_push_t push,
    input  logic       pop,
    output q_stat_t    q_stat,
    output desc_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign do_push      = push.valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.desc;
    end

endmodule

// ===== hw/rtl/etcd_back.sv =====
// ----------------------------------------------------------------------------
// etcd_back
// Walks the sixteen pixels of the head descriptor into the output register.
// ----------------------------------------------------------------------------
module etcd_back
    import etcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        alpha_mode,
    input  q_stat_t     q_stat,
    input  desc_t       head,
    output logic        pop,
    etcd_pix_if.source  pix
);

    logic [3:0]        pix_reg, pix_next;
    logic              valid_reg, valid_next;
    logic              advance, load;
    logic [1:0]        px, py;
    logic [3:0]        bit_idx;
    logic              half;
    logic [2:0]        tbl;
    logic [1:0]        sel;
    logic signed [8:0] off;
    logic [3:0]        nib;
    logic signed [9:0] sum  [3];
    logic [7:0]        chan [3];
    logic [7:0]        base;

    logic [1:0] x_reg, y_reg;
    logic [7:0] r_reg, g_reg, b_reg, a_reg;
    logic       last_reg;

    assign px      = pix_reg[1:0];
    assign py      = pix_reg[3:2];
    assign bit_idx = {px, py};
    assign half    = head.flip ? py[1] : px[1];
    assign tbl     = half ? head.tbl1 : head.tbl0;
    assign sel     = {head.sel_hi[bit_idx], head.sel_lo[bit_idx]};
    assign off     = mod_offset(tbl, sel);
    assign nib     = head.alpha[{bit_idx, 2'b00} +: 4];

    always_comb
    begin
        base = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            base     = half ? head.base1[ch] : head.base0[ch];
            sum[ch]  = signed'({2'b00, base}) + 10'(off);
            if (sum[ch] < 0)
                chan[ch] = 8'd0;
            else if (sum[ch] > 10'sd255)
                chan[ch] = 8'd255;
            else
                chan[ch] = sum[ch][7:0];
        end
    end

    assign advance    = !valid_reg || pix.ready;
    assign load       = advance && !q_stat.empty;
    assign pop        = load && (pix_reg == 4'hf);
    assign valid_next = advance ? !q_stat.empty : valid_reg;
    assign pix_next   = load ? pix_reg + 1'b1 : pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pix_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pix_reg   <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= px;
            y_reg    <= py;
            r_reg    <= chan[0];
            g_reg    <= chan[1];
            b_reg    <= chan[2];
            a_reg    <= alpha_mode ? {nib, nib} : 8'hff;
            last_reg <= (pix_reg == 4'hf);
        end
    end

    assign pix.valid      = valid_reg;
    assign pix.pixel_x    = x_reg;
    assign pix.pixel_y    = y_reg;
    assign pix.red        = r_reg;
    assign pix.green      = g_reg;
    assign pix.blue       = b_reg;
    assign pix.opacity    = a_reg;
    assign pix.last_pixel = last_reg;

endmodule

// ===== bench/etc1_block_pixel_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// etc1_block_pixel_decoder_tb
// Self-checking bench for the ETC1 block decoder. Compressed blocks go in
// over the block channel and each is decoded here into its sixteen expected
// pixels. Every pixel transfer is checked in order against them. Phases vary
// alpha_mode and the idling on both channels, and one long receiver hold-off
// backs the block up to its input.
// ----------------------------------------------------------------------------
module etc1_block_pixel_decoder_tb;
    import etcd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [ADDR_W-1:0] REG_ALPHA_MODE = 3'd0;
    localparam logic [ADDR_W-1:0] REG_UNMAPPED   = 3'd4;

    typedef struct packed {
        logic [63:0] color;
        logic [63:0] alpha;
    } block_t;

    typedef struct packed {
        logic [1:0] px;
        logic [1:0] py;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
        logic       last_pixel;
    } pixel_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    etcd_blk_if blk_ch ();
    etcd_pix_if pix_ch ();

    etc1_block_pixel_decoder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .blk     (blk_ch),
        .pix     (pix_ch)
    );

    block_t pending_blocks [$];
    pixel_t expected_pixels [$];
    block_t next_block;
    pixel_t seen_pixel;
    pixel_t want_pixel;

    logic alpha_mode_shadow;
    logic rx_hold;
    logic pressure_go;
    int   sender_idle_pct;
    int   rx_stall_pct;
    int   error_count;
    int   cycle_count;
    int   blocks_accepted;
    int   alpha_blocks;
    int   diff_blocks;
    int   pixels_checked;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int modifier(input logic [2:0] tbl, input logic [1:0] sel);
        int mag_small;
        int mag_large;
        int mag;
        case (tbl)
            3'd0: begin mag_small = 2;  mag_large = 8;   end
            3'd1: begin mag_small = 5;  mag_large = 17;  end
            3'd2: begin mag_small = 9;  mag_large = 29;  end
            3'd3: begin mag_small = 13; mag_large = 42;  end
            3'd4: begin mag_small = 18; mag_large = 60;  end
            3'd5: begin mag_small = 24; mag_large = 80;  end
            3'd6: begin mag_small = 33; mag_large = 106; end
            default: begin mag_small = 47; mag_large = 183; end
        endcase
        mag = sel[0] ? mag_large : mag_small;
        return sel[1] ? -mag : mag;
    endfunction

    function automatic logic [63:0] make_color(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [2:0] t0,
                                               input logic [2:0] t1, input logic diff,
                                               input logic flip, input logic [31:0] sel);
        return {r, g, b, t0, t1, diff, flip, sel};
    endfunction

    // Expected pixels of one block, row-major
    task automatic decode_block(input logic [63:0] cw, input logic [63:0] aw);
        int         base0 [3];
        int         base1 [3];
        int         hi;
        int         b5;
        int         dlt;
        int         half;
        int         idx;
        int         off;
        int         chan;
        logic [2:0] tbl;
        logic [1:0] sel;
        pixel_t     p;
        for (int ch = 0; ch < 3; ch++)
        begin
            hi = 59 - 8 * ch;
            if (cw[33])
            begin
                b5  = int'((cw >> hi) & 64'h1f);
                dlt = int'((cw >> (hi - 3)) & 64'h7);
                if (dlt >= 4)
                    dlt -= 8;
                base0[ch] = (b5 << 3) | (b5 >> 2);
                b5 = clamp_int(b5 + dlt, 0, 31);
                base1[ch] = (b5 << 3) | (b5 >> 2);
            end
            else
            begin
                base0[ch] = int'((cw >> (hi + 1)) & 64'hf) * 17;
                base1[ch] = int'((cw >> (hi - 3)) & 64'hf) * 17;
            end
        end
        for (int y = 0; y < 4; y++)
        begin
            for (int x = 0; x < 4; x++)
            begin
                half = cw[32] ? (y >= 2) : (x >= 2);
                tbl  = half ? cw[36:34] : cw[39:37];
                idx  = x * 4 + y;
                sel  = {cw[idx + 16], cw[idx]};
                off  = modifier(tbl, sel);
                p.px = 2'(x);
                p.py = 2'(y);
                chan = (half ? base1[0] : base0[0]) + off;
                p.red = 8'(clamp_int(chan, 0, 255));
                chan = (half ? base1[1] : base0[1]) + off;
                p.green = 8'(clamp_int(chan, 0, 255));
                chan = (half ? base1[2] : base0[2]) + off;
                p.blue = 8'(clamp_int(chan, 0, 255));
                p.opacity = alpha_mode_shadow ? 8'(aw[idx * 4 +: 4] * 17) : 8'd255;
                p.last_pixel = (x == 3) && (y == 3);
                expected_pixels.push_back(p);
            end
        end
        if (alpha_mode_shadow)
            alpha_blocks++;
        if (cw[33])
            diff_blocks++;
    endtask

    // Block channel driver
    always @(posedge clk)
    begin
        if (!rst_n)
            blk_ch.valid <= 1'b0;
        else if (!blk_ch.valid || blk_ch.ready)
        begin
            if (blk_ch.valid)
            begin
                decode_block(blk_ch.color_block, blk_ch.alpha_block);
                blocks_accepted++;
            end
            if (pending_blocks.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_block = pending_blocks.pop_front();
                blk_ch.valid       <= 1'b1;
                blk_ch.color_block <= next_block.color;
                blk_ch.alpha_block <= next_block.alpha;
            end
            else
                blk_ch.valid <= 1'b0;
        end
    end

    // Pixel channel monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            pix_ch.ready <= 1'b0;
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                seen_pixel.px         = pix_ch.pixel_x;
                seen_pixel.py         = pix_ch.pixel_y;
                seen_pixel.red        = pix_ch.red;
                seen_pixel.green      = pix_ch.green;
                seen_pixel.blue       = pix_ch.blue;
                seen_pixel.opacity    = pix_ch.opacity;
                seen_pixel.last_pixel = pix_ch.last_pixel;
                pixels_checked++;
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected pixel x=%0d y=%0d rgba=%h%h%h%h last=%0d",
                             $time, seen_pixel.px, seen_pixel.py, seen_pixel.red,
                             seen_pixel.green, seen_pixel.blue, seen_pixel.opacity,
                             seen_pixel.last_pixel);
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (seen_pixel !== want_pixel)
                    begin
                        error_count++;
                        $display("%0t: pixel mismatch", $time);
                        $display("  expected x=%0d y=%0d r=%h g=%h b=%h a=%h last=%0d",
                                 want_pixel.px, want_pixel.py, want_pixel.red,
                                 want_pixel.green, want_pixel.blue, want_pixel.opacity,
                                 want_pixel.last_pixel);
                        $display("  actual   x=%0d y=%0d r=%h g=%h b=%h a=%h last=%0d",
                                 seen_pixel.px, seen_pixel.py, seen_pixel.red,
                                 seen_pixel.green, seen_pixel.blue, seen_pixel.opacity,
                                 seen_pixel.last_pixel);
                    end
                end
            end
            pix_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_ALPHA_MODE)
            alpha_mode_shadow = data[0];
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || blk_ch.valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        block_t b;
        @(negedge clk);
        sender_idle_pct = idle_pct;
        rx_stall_pct    = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            b.color = {$urandom, $urandom};
            b.alpha = {$urandom, $urandom};
            // push some blocks towards the differential clamp at either end
            case ($urandom_range(5))
                0: b.color[63:33] = {8'hfb, 8'hfa, 8'hf9, b.color[39:34], 1'b1};
                1: b.color[63:33] = {8'h04, 8'h05, 8'h06, b.color[39:34], 1'b1};
                default: ;
            endcase
            if ($urandom_range(7) == 0)
                b.alpha = $urandom_range(1) ? 64'hffff_ffff_ffff_ffff : 64'h0;
            pending_blocks.push_back(b);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        blk_ch.valid       = 1'b0;
        blk_ch.color_block = '0;
        blk_ch.alpha_block = '0;
        pix_ch.ready       = 1'b0;
        rx_hold            = 1'b0;
        pressure_go        = 1'b0;
        alpha_mode_shadow  = 1'b0;
        sender_idle_pct    = 0;
        rx_stall_pct       = 0;
        error_count        = 0;
        cycle_count        = 0;
        blocks_accepted    = 0;
        alpha_blocks       = 0;
        diff_blocks        = 0;
        pixels_checked     = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Opaque mode: alpha word must be ignored
        apb_write(REG_ALPHA_MODE, 32'h0);
        @(negedge clk);
        pending_blocks.push_back('{64'h0, 64'h0});
        pending_blocks.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
        pending_blocks.push_back('{make_color(8'hfb, 8'hfb, 8'hfb, 3'd7, 3'd7, 1'b1, 1'b0,
                                              32'hffff_0000), 64'h0123_4567_89ab_cdef});
        pending_blocks.push_back('{make_color(8'h04, 8'h04, 8'h04, 3'd0, 3'd0, 1'b1, 1'b1,
                                              32'h0000_ffff), 64'h0});
        pending_blocks.push_back('{make_color(8'hf0, 8'h0f, 8'hff, 3'd3, 3'd4, 1'b0, 1'b1,
                                              32'h5a5a_a5a5), 64'h0});
        for (int t = 0; t < 8; t++)
            pending_blocks.push_back('{make_color(8'($urandom), 8'($urandom), 8'($urandom),
                                                  3'(t), 3'(7 - t), t[0], t[1], $urandom),
                                       {$urandom, $urandom}});
        wait_drained();

        // Alpha mode via a value with upper bits set; unmapped write is a no-op
        apb_write(REG_ALPHA_MODE, 32'hffff_ffff);
        apb_write(REG_UNMAPPED, 32'h0);
        @(negedge clk);
        pending_blocks.push_back('{64'h0, 64'h0});
        pending_blocks.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
        pending_blocks.push_back('{make_color(8'h0c, 8'hf3, 8'h7f, 3'd7, 3'd0, 1'b1, 1'b0,
                                              32'hf0f0_0f0f), 64'hf0f0_f0f0_0f0f_0f0f});
        pending_blocks.push_back('{make_color(8'hff, 8'h00, 8'h88, 3'd6, 3'd1, 1'b0, 1'b0,
                                              32'hffff_ffff), 64'h0123_4567_89ab_cdef});
        pending_blocks.push_back('{make_color(8'h03, 8'hfc, 8'h84, 3'd2, 3'd5, 1'b1, 1'b1,
                                              32'h0000_0000), 64'hfedc_ba98_7654_3210});
        pending_blocks.push_back('{make_color(8'h77, 8'hbb, 8'h11, 3'd4, 3'd3, 1'b0, 1'b1,
                                              32'h1234_5678), 64'h5555_aaaa_5555_aaaa});
        wait_drained();

        run_random(40, 0, 0);

        apb_write(REG_ALPHA_MODE, 32'hffff_fffe);
        run_random(40, 82, 0);

        apb_write(REG_ALPHA_MODE, 32'h1);
        run_random(40, 0, 82);

        pressure_go = 1'b1;
        run_random(40, 21, 21);

        apb_write(REG_ALPHA_MODE, 32'h0);
        run_random(30, 0, 0);

        $display("Covered %0d blocks (%0d with explicit alpha, %0d differential)",
                 blocks_accepted, alpha_blocks, diff_blocks);
        $display("and %0d pixel transfers across idle, stall and hold-off phases",
                 pixels_checked);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
